### design/ifla_pkg.sv
package ifla_pkg;

  localparam int MaxIds     = 1024;
  localparam int StoreDepth = 1024;
  localparam int IdW        = 10;
  localparam int GrantW     = 11;
  localparam int StatusW    = 2;
  localparam int UsableLim  = (MaxIds - 1 < StoreDepth) ? MaxIds - 1 : StoreDepth;

  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree  = 1'b1;

  typedef enum logic [StatusW-1:0] {
    StGranted   = 2'd0,
    StExhausted = 2'd1,
    StFreed     = 2'd2,
    StIgnored   = 2'd3
  } status_e;

  typedef struct packed {
    logic           func;
    logic [IdW-1:0] release_id;
  } in_t;

  typedef struct packed {
    logic [GrantW-1:0] granted_id;
    status_e           status;
  } out_t;

  typedef struct packed {
    logic clear_en;
    logic issue;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_blocked;
  } dp_status_t;

  function automatic logic [GrantW-1:0] usable_count(input logic [IdW-1:0] cnt);
    logic [GrantW-1:0] lim;
    lim = GrantW'(UsableLim);
    usable_count = ({1'b0, cnt} > lim) ? lim : {1'b0, cnt};
  endfunction

endpackage

### design/id_free_list_allocator.sv
// A transaction's operands and memory reads are registered when it is accepted; its
//   result is registered at commit, which waits while the output is stalled.
// Transactions do not overlap: input is stalled until the result commits, set by the
//   single-port read then write-back of the identifier stack and taken-flag memories.
// Reset and every id_count write start a clearing pass over all 1024 entries of both
//   memories; input is stalled until it completes.
module id_free_list_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ifla_pkg::IdW-1:0]       cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ifla_pkg::in_t                  in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ifla_pkg::out_t                 out_o
);

  ifla_pkg::dp_cmd_t    cmd;
  ifla_pkg::dp_status_t sts;

  ifla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  ifla_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule

### design/ifla_ctrl.sv
module ifla_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                in_valid_i,
  input  ifla_pkg::dp_status_t sts_i,
  output ifla_pkg::dp_cmd_t   cmd_o,
  output logic                in_stall_o
);

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StLookup
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else if (cfg_we_i) begin
      state_q <= StClear;
    end else begin
      case (state_q)
        StClear: begin
          if (sts_i.clear_last) state_q <= StIdle;
        end
        StIdle: begin
          if (in_valid_i) state_q <= StLookup;
        end
        StLookup: begin
          if (!sts_i.out_blocked) state_q <= StIdle;
        end
        default: state_q <= StClear;
      endcase
    end
  end

  always_comb begin
    cmd_o.clear_en = (state_q == StClear) && !cfg_we_i;
    cmd_o.issue    = (state_q == StIdle) && in_valid_i;
    cmd_o.commit   = (state_q == StLookup) && !sts_i.out_blocked;
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

### design/ifla_dp.sv
module ifla_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ifla_pkg::IdW-1:0]       cfg_wdata_i,
  input  ifla_pkg::in_t                  in_i,
  input  ifla_pkg::dp_cmd_t              cmd_i,
  output ifla_pkg::dp_status_t           sts_o,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output ifla_pkg::out_t                 out_o
);

  localparam int IdW    = ifla_pkg::IdW;
  localparam int GrantW = ifla_pkg::GrantW;

  logic [IdW-1:0]    stack_mem [ifla_pkg::StoreDepth];
  logic              flag_mem  [ifla_pkg::StoreDepth];

  logic [IdW-1:0]    count_q;
  logic [GrantW-1:0] taken_q, taken_d;
  logic [IdW-1:0]    clr_idx_q;
  logic              out_valid_q;
  ifla_pkg::out_t    out_q, out_d;

  logic              func_q;
  logic [IdW-1:0]    rel_q;
  logic [IdW-1:0]    stack_rd_q;
  logic              flag_rd_q;

  logic [GrantW-1:0] n_lim;
  logic              grant_ok, free_ok;
  logic [GrantW-1:0] taken_dec;

  logic              stack_we, flag_we, flag_wd;
  logic [IdW-1:0]    stack_wa, stack_wd, flag_wa;

  assign n_lim     = ifla_pkg::usable_count(count_q);
  assign taken_dec = taken_q - GrantW'(1);
  assign grant_ok  = (func_q == ifla_pkg::FuncAlloc) && (taken_q < n_lim);
  assign free_ok   = (func_q == ifla_pkg::FuncFree) && ({1'b0, rel_q} < n_lim)
                     && (taken_q != '0) && flag_rd_q;

  assign sts_o.clear_last  = (clr_idx_q == IdW'(ifla_pkg::StoreDepth - 1));
  assign sts_o.out_blocked = out_valid_q && out_stall_i;

  always_comb begin
    stack_we = 1'b0;
    stack_wa = clr_idx_q;
    stack_wd = clr_idx_q;
    flag_we  = 1'b0;
    flag_wa  = clr_idx_q;
    flag_wd  = 1'b0;
    taken_d  = taken_q;
    out_d    = out_q;
    if (cmd_i.clear_en) begin
      stack_we = 1'b1;
      flag_we  = 1'b1;
    end else if (cmd_i.commit) begin
      if (func_q == ifla_pkg::FuncAlloc) begin
        if (grant_ok) begin
          flag_we          = 1'b1;
          flag_wa          = stack_rd_q;
          flag_wd          = 1'b1;
          taken_d          = taken_q + GrantW'(1);
          out_d.granted_id = {1'b0, stack_rd_q};
          out_d.status     = ifla_pkg::StGranted;
        end else begin
          out_d.granted_id = GrantW'(ifla_pkg::MaxIds);
          out_d.status     = ifla_pkg::StExhausted;
        end
      end else begin
        out_d.granted_id = '0;
        if (free_ok) begin
          stack_we     = 1'b1;
          stack_wa     = taken_dec[IdW-1:0];
          stack_wd     = rel_q;
          flag_we      = 1'b1;
          flag_wa      = rel_q;
          flag_wd      = 1'b0;
          taken_d      = taken_dec;
          out_d.status = ifla_pkg::StFreed;
        end else begin
          out_d.status = ifla_pkg::StIgnored;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) stack_mem[stack_wa] <= stack_wd;
    if (cmd_i.issue) stack_rd_q <= stack_mem[taken_q[IdW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (flag_we) flag_mem[flag_wa] <= flag_wd;
    if (cmd_i.issue) flag_rd_q <= flag_mem[in_i.release_id];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      func_q <= in_i.func;
      rel_q  <= in_i.release_id;
    end
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= IdW'(ifla_pkg::StoreDepth - 1);
      taken_q     <= '0;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q   <= cfg_wdata_i;
        taken_q   <= '0;
        clr_idx_q <= '0;
      end else begin
        taken_q <= taken_d;
        if (cmd_i.clear_en && !sts_o.clear_last) clr_idx_q <= clr_idx_q + IdW'(1);
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef NO_ASSERTIONS
  a_taken_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    taken_q <= n_lim) else $error("allocated count exceeds usable identifiers");

  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_en |-> taken_q == '0) else $error("allocations present while clearing");

  a_grant_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && grant_ok && !cfg_we_i) |=> taken_q == $past(taken_q) + GrantW'(1))
    else $error("grant did not advance the stack pointer");

  a_exhaust_sentinel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ifla_pkg::StExhausted)
      |-> out_q.granted_id == GrantW'(ifla_pkg::MaxIds))
    else $error("exhausted transaction without sentinel");
`endif

endmodule
